>>> rtl/core/scfr_pkg.sv
// scfr_pkg: constants, types and state encoding for the serial command frame receiver
// no dependencies; used by the interfaces, controller, datapath and top level

package scfr_pkg;

   // payload store size and field widths
   localparam int PAYLOAD_CAPACITY = 64;
   localparam int BYTE_W           = 8;
   localparam int SIZE_W           = $clog2(PAYLOAD_CAPACITY + 1);
   localparam int INDEX_W          = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;

   // frame header characters
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_M      = 8'h4D;
   localparam logic [BYTE_W-1:0] CHAR_LT     = 8'h3C;

   // largest acceptable size byte
   localparam logic [BYTE_W-1:0] SIZE_LIMIT  = BYTE_W'(PAYLOAD_CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOLLAR,
      ST_M,
      ST_ARROW,
      ST_SIZE,
      ST_PAYLOAD,
      ST_EMIT_RD,
      ST_EMIT_LD
   } scfr_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_size;
      logic load_cmd;
      logic store_byte;
      logic start_emit;
      logic rd_issue;
      logic out_load;
   } scfr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_dollar;
      logic is_m;
      logic is_lt;
      logic size_ok;
      logic count_lt_size;
      logic cksum_ok;
      logic emit_last;
      logic slot_free;
   } scfr_status_type;

endpackage

>>> rtl/core/scfr_req_if.sv
// scfr_req_if: received byte channel, valid/ready handshake
// depends on scfr_pkg

interface scfr_req_if;
   import scfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/scfr_rsp_if.sv
// scfr_rsp_if: frame result channel, valid/ready handshake
// depends on scfr_pkg

interface scfr_rsp_if;
   import scfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  command;
   logic [SIZE_W-1:0]  payload_size;
   logic [INDEX_W-1:0] byte_index;
   logic [BYTE_W-1:0]  payload_byte;
   logic               last;

   modport source (output valid, output command, output payload_size, output byte_index,
                   output payload_byte, output last, input ready);
   modport sink   (input valid, input command, input payload_size, input byte_index,
                   input payload_byte, input last, output ready);
endinterface

>>> rtl/core/scfr_ram.sv
// scfr_ram: generic single write port, single read port RAM with registered read
// no dependencies

module scfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/scfr_ctrl.sv
// scfr_ctrl: frame parser and emission controller state machine
// depends on scfr_pkg; drives commands to scfr_datapath

module scfr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  scfr_pkg::scfr_status_type status,
   output scfr_pkg::scfr_cmd_type    cmd
);
   import scfr_pkg::*;

   scfr_state_type state_ff;
   scfr_state_type state_in;
   logic           accept;

   // bytes are taken only in the parsing states
   always_comb begin
      unique case (state_ff)
         ST_EMIT_RD, ST_EMIT_LD: req_ready = 1'b0;
         default:                req_ready = 1'b1;
      endcase
   end

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = status.is_dollar ? ST_DOLLAR : ST_IDLE;
         end
         ST_DOLLAR: begin
            if (accept) state_in = status.is_m ? ST_M : ST_IDLE;
         end
         ST_M: begin
            if (accept) state_in = status.is_lt ? ST_ARROW : ST_IDLE;
         end
         ST_ARROW: begin
            if (accept) state_in = status.size_ok ? ST_SIZE : ST_IDLE;
         end
         ST_SIZE: begin
            if (accept) state_in = ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            if (accept && !status.count_lt_size) begin
               state_in = status.cksum_ok ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.slot_free) state_in = status.emit_last ? ST_IDLE : ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_ARROW: begin
            cmd.load_size = accept && status.size_ok;
         end
         ST_SIZE: begin
            cmd.load_cmd = accept;
         end
         ST_PAYLOAD: begin
            cmd.store_byte = accept && status.count_lt_size;
            cmd.start_emit = accept && !status.count_lt_size && status.cksum_ok;
         end
         ST_EMIT_RD: begin
            cmd.rd_issue = 1'b1;
         end
         ST_EMIT_LD: begin
            cmd.out_load = status.slot_free;
         end
         default: cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/scfr_datapath.sv
// scfr_datapath: frame registers, checksum, payload store and result register
// depends on scfr_pkg and scfr_ram; controlled by scfr_ctrl

module scfr_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [scfr_pkg::BYTE_W-1:0]  rx_byte,
   input  scfr_pkg::scfr_cmd_type       cmd,
   output scfr_pkg::scfr_status_type    status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [scfr_pkg::BYTE_W-1:0]  rsp_command,
   output logic [scfr_pkg::SIZE_W-1:0]  rsp_payload_size,
   output logic [scfr_pkg::INDEX_W-1:0] rsp_byte_index,
   output logic [scfr_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                         rsp_last
);
   import scfr_pkg::*;

   logic [SIZE_W-1:0]  size_ff;
   logic [SIZE_W-1:0]  count_ff;
   logic [BYTE_W-1:0]  cksum_ff;
   logic [BYTE_W-1:0]  command_ff;
   logic [INDEX_W-1:0] emit_idx_ff;
   logic [BYTE_W-1:0]  ram_rd_data;
   logic               size_zero;

   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_command_ff;
   logic [SIZE_W-1:0]  out_size_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_last_ff;

   assign size_zero = (size_ff == '0);

   // status towards the controller
   always_comb begin
      status.is_dollar     = (rx_byte == CHAR_DOLLAR);
      status.is_m          = (rx_byte == CHAR_M);
      status.is_lt         = (rx_byte == CHAR_LT);
      status.size_ok       = (rx_byte <= SIZE_LIMIT);
      status.count_lt_size = (count_ff < size_ff);
      status.cksum_ok      = (cksum_ff == rx_byte);
      status.emit_last     = size_zero || ((SIZE_W'(emit_idx_ff) + SIZE_W'(1)) == size_ff);
      status.slot_free     = !out_valid_ff || rsp_ready;
   end

   // frame size, count, checksum and command
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= '0;
         count_ff   <= '0;
         cksum_ff   <= '0;
         command_ff <= '0;
      end else begin
         if (cmd.load_size) begin
            size_ff  <= SIZE_W'(rx_byte);
            count_ff <= '0;
            cksum_ff <= rx_byte;
         end
         if (cmd.load_cmd) begin
            command_ff <= rx_byte;
            cksum_ff   <= cksum_ff ^ rx_byte;
         end
         if (cmd.store_byte) begin
            count_ff <= count_ff + SIZE_W'(1);
            cksum_ff <= cksum_ff ^ rx_byte;
         end
      end
   end

   // emission index
   always_ff @(posedge clock) begin
      if (cmd.start_emit) begin
         emit_idx_ff <= '0;
      end else if (cmd.out_load) begin
         emit_idx_ff <= emit_idx_ff + INDEX_W'(1);
      end
   end

   // payload store
   scfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PAYLOAD_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (count_ff[INDEX_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (emit_idx_ff),
      .rd_data (ram_rd_data)
   );

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_command_ff <= command_ff;
         out_size_ff    <= size_ff;
         out_index_ff   <= emit_idx_ff;
         out_byte_ff    <= size_zero ? '0 : ram_rd_data;
         out_last_ff    <= status.emit_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command      = out_command_ff;
   assign rsp_payload_size = out_size_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_last         = out_last_ff;

endmodule

>>> rtl/core/serial_command_frame_receiver.sv
// serial_command_frame_receiver: one received byte per transaction, taken every clock while
// parsing. after a good checksum byte the input stalls while results are sent: each result
// is a store read followed by a result register load, and the load waits while the result
// register holds a result not yet taken; a frame with no payload gives a single result.
// synchronous active-high reset returns the parser to idle and empties the result register.
// depends on scfr_pkg, scfr_req_if, scfr_rsp_if, scfr_ctrl, scfr_datapath

module serial_command_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   scfr_req_if.sink    req_chan,
   scfr_rsp_if.source  rsp_chan
);
   import scfr_pkg::*;

   scfr_cmd_type    cmd;
   scfr_status_type status;

   // parser and emission controller
   scfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame registers, store and result register
   scfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .rx_byte          (req_chan.rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_command      (rsp_chan.command),
      .rsp_payload_size (rsp_chan.payload_size),
      .rsp_byte_index   (rsp_chan.byte_index),
      .rsp_payload_byte (rsp_chan.payload_byte),
      .rsp_last         (rsp_chan.last)
   );

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for serial_command_frame_receiver, directed frames then random
// byte streams under several idle/stall mixes, checked against an in-bench frame parser
// depends on scfr_pkg, scfr_req_if, scfr_rsp_if and the serial_command_frame_receiver rtl
`timescale 1ns / 100ps

module tb_top;
   import scfr_pkg::*;

   localparam int CLK_HALF      = 2;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int RANDOM_ITEMS  = 180;
   localparam int NUM_PHASES    = 4;

   typedef struct packed {
      logic [BYTE_W-1:0]  command;
      logic [SIZE_W-1:0]  payload_size;
      logic [INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last;
   } frame_result_type;

   typedef struct {
      logic [BYTE_W-1:0] rx;
      bit                typed;
      frame_result_type  res;
   } stim_row_type;

   logic clock;
   logic reset;

   scfr_req_if req_chan ();
   scfr_rsp_if rsp_chan ();

   serial_command_frame_receiver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // frame parser copy
   scfr_state_type    parser_state;
   logic [SIZE_W-1:0] frame_size;
   logic [SIZE_W-1:0] bytes_seen;
   logic [BYTE_W-1:0] xor_sum;
   logic [BYTE_W-1:0] frame_cmd;
   logic [BYTE_W-1:0] payload_copy [PAYLOAD_CAPACITY];

   frame_result_type pending_results [$];
   stim_row_type     directed_rows [$];

   int  src_idle_pct  = 0;
   int  sink_stall_pct = 0;
   int  items_sent    = 0;
   int  cycle_count   = 0;
   bit  failed        = 0;

   // clock
   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("** serial_command_frame_receiver: FAILED **");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   // push the results of a completed frame
   function automatic void emit_frame();
      frame_result_type r;
      if (frame_size == 0) begin
         r = {frame_cmd, SIZE_W'(0), INDEX_W'(0), BYTE_W'(0), 1'b1};
         pending_results.push_back(r);
      end else begin
         for (int k = 0; k < frame_size; k++) begin
            r.command      = frame_cmd;
            r.payload_size = frame_size;
            r.byte_index   = INDEX_W'(k);
            r.payload_byte = payload_copy[INDEX_W'(k)];
            r.last         = (k + 1 == frame_size);
            pending_results.push_back(r);
         end
      end
   endfunction

   // one received byte through the parser
   function automatic void predict_byte(input logic [BYTE_W-1:0] rx);
      case (parser_state)
         ST_DOLLAR: begin
            parser_state = (rx == CHAR_M) ? ST_M : ST_IDLE;
         end
         ST_M: begin
            parser_state = (rx == CHAR_LT) ? ST_ARROW : ST_IDLE;
         end
         ST_ARROW: begin
            if (rx > SIZE_LIMIT) begin
               parser_state = ST_IDLE;
            end else begin
               frame_size   = rx[SIZE_W-1:0];
               bytes_seen   = '0;
               xor_sum      = rx;
               parser_state = ST_SIZE;
            end
         end
         ST_SIZE: begin
            frame_cmd    = rx;
            xor_sum      = xor_sum ^ rx;
            parser_state = ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            if (bytes_seen < frame_size) begin
               xor_sum = xor_sum ^ rx;
               payload_copy[bytes_seen[INDEX_W-1:0]] = rx;
               bytes_seen++;
            end else begin
               if (xor_sum == rx) emit_frame();
               parser_state = ST_IDLE;
            end
         end
         default: begin
            parser_state = (rx == CHAR_DOLLAR) ? ST_DOLLAR : ST_IDLE;
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         failed = 1'b1;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // result checking
   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            failed = 1'b1;
            $display("%0t: unexpected result: expected none", $time);
            $display("   actual cmd %0h size %0d idx %0d byte %0h last %0b",
                     rsp_chan.command, rsp_chan.payload_size, rsp_chan.byte_index,
                     rsp_chan.payload_byte, rsp_chan.last);
         end else begin
            want = pending_results.pop_front();
            check_field("command", want.command, rsp_chan.command);
            check_field("payload_size", want.payload_size, rsp_chan.payload_size);
            check_field("byte_index", want.byte_index, rsp_chan.byte_index);
            check_field("payload_byte", want.payload_byte, rsp_chan.payload_byte);
            check_field("last", want.last, rsp_chan.last);
         end
      end
   end

   // drive one byte transaction, with random idle cycles ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] rx, input bit typed,
                            input frame_result_type typed_res);
      int before_n;
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      before_n = pending_results.size();
      predict_byte(rx);
      // a typed row replaces what the parser worked out
      if (typed) begin
         while (pending_results.size() > before_n) void'(pending_results.pop_back());
         pending_results.push_back(typed_res);
      end
   endtask

   task automatic add_row(input logic [BYTE_W-1:0] rx, input bit typed,
                          input frame_result_type res);
      stim_row_type row;
      row.rx    = rx;
      row.typed = typed;
      row.res   = res;
      directed_rows.push_back(row);
   endtask

   // one random frame, mostly well formed, else broken or noise
   task automatic send_random_frame(input bit full_size);
      logic [BYTE_W-1:0] body [$];
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] b;
      int pick;
      int size;
      pick = full_size ? 0 : $urandom_range(0, 99);
      if (pick < 75) begin
         if (full_size) size = PAYLOAD_CAPACITY;
         else if ($urandom_range(0, 19) == 0)
            size = $urandom_range(PAYLOAD_CAPACITY - 2, PAYLOAD_CAPACITY);
         else size = $urandom_range(0, 8);
         cmd = $urandom_range(0, 255);
         body.push_back(CHAR_DOLLAR);
         body.push_back(CHAR_M);
         body.push_back(CHAR_LT);
         body.push_back(BYTE_W'(size));
         body.push_back(cmd);
         sum = BYTE_W'(size) ^ cmd;
         repeat (size) begin
            b = $urandom_range(0, 255);
            body.push_back(b);
            sum = sum ^ b;
         end
         // corrupted checksum
         if (pick >= 65) sum = sum ^ BYTE_W'($urandom_range(1, 255));
         body.push_back(sum);
      end else if (pick < 82) begin
         // oversize frame
         body.push_back(CHAR_DOLLAR);
         body.push_back(CHAR_M);
         body.push_back(CHAR_LT);
         body.push_back(BYTE_W'($urandom_range(PAYLOAD_CAPACITY + 1, 255)));
      end else if (pick < 90) begin
         // broken header
         body.push_back(CHAR_DOLLAR);
         if ($urandom_range(0, 1)) begin
            do b = $urandom_range(0, 255); while (b == CHAR_M);
         end else begin
            body.push_back(CHAR_M);
            do b = $urandom_range(0, 255); while (b == CHAR_LT);
         end
         body.push_back(b);
      end else begin
         // line noise
         repeat ($urandom_range(1, 4)) body.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      foreach (body[i]) send_byte(body[i], 1'b0, '0);
   endtask

   // main sequence
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      reset            = 1'b1;
      parser_state     = ST_IDLE;
      frame_size       = '0;
      bytes_seen       = '0;
      xor_sum          = '0;
      frame_cmd        = '0;

      // empty payload frame
      add_row(CHAR_DOLLAR, 1'b0, '0);
      add_row(CHAR_M, 1'b0, '0);
      add_row(CHAR_LT, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);
      add_row(8'h64, 1'b0, '0);
      add_row(8'h64, 1'b1, {8'h64, SIZE_W'(0), INDEX_W'(0), 8'h00, 1'b1});
      // wrong byte after the dollar
      add_row(CHAR_DOLLAR, 1'b0, '0);
      add_row(CHAR_LT, 1'b0, '0);
      // single payload byte, byte extremes
      add_row(CHAR_DOLLAR, 1'b0, '0);
      add_row(CHAR_M, 1'b0, '0);
      add_row(CHAR_LT, 1'b0, '0);
      add_row(8'h01, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);
      add_row(8'hFF, 1'b0, '0);
      add_row(8'hFE, 1'b1, {8'h00, SIZE_W'(1), INDEX_W'(0), 8'hFF, 1'b1});
      // wrong byte after the M, a dollar that must not restart the header
      add_row(CHAR_DOLLAR, 1'b0, '0);
      add_row(CHAR_M, 1'b0, '0);
      add_row(CHAR_DOLLAR, 1'b0, '0);
      // size just above capacity
      add_row(CHAR_DOLLAR, 1'b0, '0);
      add_row(CHAR_M, 1'b0, '0);
      add_row(CHAR_LT, 1'b0, '0);
      add_row(SIZE_LIMIT + 8'd1, 1'b0, '0);
      // bad checksum, dropped
      add_row(CHAR_DOLLAR, 1'b0, '0);
      add_row(CHAR_M, 1'b0, '0);
      add_row(CHAR_LT, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);
      add_row(8'hFF, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);

      // random phases with different idle mixes
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
            default: begin src_idle_pct = 11; sink_stall_pct = 11; end
         endcase
         send_random_frame(p == 0);
         while (items_sent < directed_rows.size() + (p + 1) * RANDOM_ITEMS / NUM_PHASES)
            send_random_frame(1'b0);
         // sender holds off until every result is out
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while (pending_results.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         failed = 1'b1;
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      end
      if (!failed) begin
         $display("** serial_command_frame_receiver: PASSED **");
      end else begin
         $display("** serial_command_frame_receiver: FAILED **");
      end
      $finish;
   end

endmodule

>>> serial_command_frame_receiver.f
rtl/core/scfr_pkg.sv
rtl/core/scfr_req_if.sv
rtl/core/scfr_rsp_if.sv
rtl/core/scfr_ram.sv
rtl/core/scfr_ctrl.sv
rtl/core/scfr_datapath.sv
rtl/core/serial_command_frame_receiver.sv
test/tb_top.sv
